// File: design/unfn_pkg.sv
// Shared constants and the control type for the triangle unit-normal pipeline.
package unfn_pkg;

    localparam int unsigned COORD_WIDTH_DEF = 32;
    localparam int unsigned NORMAL_FRAC_DEF = 30;
    localparam int unsigned OUT_WIDTH       = 32;
    localparam int unsigned FRONT_STAGES    = 6;

    typedef struct packed {
        logic       valid;
        logic       degenerate;
        logic [2:0] neg;
    } t_ctl;

endpackage

// File: design/unfn_if.sv
// Request channels: triangle corners in, unit normal out.
interface unfn_in_if #(parameter int unsigned CW = 32);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] c_z;
    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
    modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface unfn_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic               degenerate;
    modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
    modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// File: design/unit_normal_from_three_points.sv
// Top level of the triangle unit-normal pipeline.
//
//  channel | dir | fields                                  | format
//  i_in    | in  | a_x a_y a_z b_x b_y b_z c_x c_y c_z     | signed COORD_WIDTH
//  o_out   | out | normal_x normal_y normal_z degenerate   | signed Q2.30, flag
//
// One request per cycle while the output is not held. The path is six front
// stages, one cell per quotient bit, and the output register.
// Every stage holds only while the stage after it is full and held, so bubbles
// close up; input is still taken while a result waits if any stage is empty.
// Reset clears the valid bits of all stages; no clearing pass is needed.
module unit_normal_from_three_points #(
    parameter int unsigned COORD_WIDTH = unfn_pkg::COORD_WIDTH_DEF,
    parameter int unsigned NORMAL_FRAC = unfn_pkg::NORMAL_FRAC_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    unfn_in_if.sink   i_in,
    unfn_out_if.source o_out
);
    import unfn_pkg::*;

    localparam int unsigned MW = 2 * (COORD_WIDTH + 1) + 1;
    localparam int unsigned RW = 2 * MW + 2 + 2 * NORMAL_FRAC + 3;
    localparam int unsigned QW = NORMAL_FRAC + 1;
    localparam int unsigned NC = QW;
    localparam int unsigned XW = QW + OUT_WIDTH + 1;

    logic signed [COORD_WIDTH-1:0] w_pts [9];
    logic [FRONT_STAGES-1:0]       w_fv;
    logic [FRONT_STAGES-1:0]       w_fen;
    logic [NC:0]                   w_cen;
    logic                          w_oen;

    t_ctl               w_ctl [NC+1];
    logic [RW-1:0]      w_s [NC+1];
    logic [2:0][RW-1:0] w_r [NC+1];
    logic [2:0][RW-1:0] w_y [NC+1];
    logic [2:0][QW-1:0] w_q [NC+1];

    logic                        r_ov, r_odeg;
    logic signed [OUT_WIDTH-1:0] r_on [3];
    logic signed [OUT_WIDTH-1:0] n_on [3];
    logic [XW-1:0]               w_qx [3];
    logic [XW-1:0]               w_mag [3];

    assign w_pts[0] = i_in.a_x;
    assign w_pts[1] = i_in.a_y;
    assign w_pts[2] = i_in.a_z;
    assign w_pts[3] = i_in.b_x;
    assign w_pts[4] = i_in.b_y;
    assign w_pts[5] = i_in.b_z;
    assign w_pts[6] = i_in.c_x;
    assign w_pts[7] = i_in.c_y;
    assign w_pts[8] = i_in.c_z;

    // Stage enables: a stage loads when it is empty or the next one loads.
    assign w_oen     = !r_ov || o_out.ready;
    assign w_cen[NC] = w_oen;
    genvar g;
    generate
        for (g = 0; g < NC; g++) begin : g_cen
            assign w_cen[g] = !w_ctl[g+1].valid || w_cen[g+1];
        end
        for (g = 0; g < FRONT_STAGES - 1; g++) begin : g_fen
            assign w_fen[g] = !w_fv[g] || w_fen[g+1];
        end
    endgenerate
    assign w_fen[FRONT_STAGES-1] = !w_fv[FRONT_STAGES-1] || w_cen[0];
    assign i_in.ready = w_fen[0];

    unfn_front #(.CW(COORD_WIDTH), .F(NORMAL_FRAC), .MW(MW), .RW(RW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_fen),
        .i_valid (i_in.valid),
        .i_pts   (w_pts),
        .o_v     (w_fv),
        .o_ctl   (w_ctl[0]),
        .o_s     (w_s[0]),
        .o_r     (w_r[0])
    );
    assign w_y[0] = '0;
    assign w_q[0] = '0;

    generate
        for (g = 0; g < NC; g++) begin : g_cell
            unfn_cell #(.RW(RW), .QW(QW), .B(NORMAL_FRAC - g)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_cen[g]),
                .i_ctl   (w_ctl[g]),
                .i_s     (w_s[g]),
                .i_r     (w_r[g]),
                .i_y     (w_y[g]),
                .i_q     (w_q[g]),
                .o_ctl   (w_ctl[g+1]),
                .o_s     (w_s[g+1]),
                .o_r     (w_r[g+1]),
                .o_y     (w_y[g+1]),
                .o_q     (w_q[g+1])
            );
        end
    endgenerate

    // Apply the sign, saturate to the output field and zero a degenerate normal.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_qx[j] = XW'(w_q[NC][j]);
            if (w_ctl[NC].neg[j]) begin
                w_mag[j] = (w_qx[j] > (XW'(1) << (OUT_WIDTH - 1)))
                           ? (XW'(1) << (OUT_WIDTH - 1)) : w_qx[j];
                n_on[j]  = OUT_WIDTH'(XW'(0) - w_mag[j]);
            end else begin
                w_mag[j] = (w_qx[j] > ((XW'(1) << (OUT_WIDTH - 1)) - XW'(1)))
                           ? ((XW'(1) << (OUT_WIDTH - 1)) - XW'(1)) : w_qx[j];
                n_on[j]  = OUT_WIDTH'(w_mag[j]);
            end
            if (w_ctl[NC].degenerate) n_on[j] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_oen) begin
            r_ov <= w_ctl[NC].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_oen) begin
            r_on   <= n_on;
            r_odeg <= w_ctl[NC].degenerate;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.normal_x   = r_on[0];
    assign o_out.normal_y   = r_on[1];
    assign o_out.normal_z   = r_on[2];
    assign o_out.degenerate = r_odeg;

    a_degen_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.degenerate) |->
        (o_out.normal_x == '0 && o_out.normal_y == '0 && o_out.normal_z == '0))
        else $error("degenerate result carries a nonzero normal");

    a_nondegen_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.degenerate) |->
        (o_out.normal_x != '0 || o_out.normal_y != '0 || o_out.normal_z != '0))
        else $error("nondegenerate result has a zero normal");

    a_stall_only_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without a held result");

    a_reset_empty : assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result valid right after reset");

endmodule

// File: design/unfn_front.sv
// Front stages: edge vectors, cross product, squares and the sum of squares.
module unfn_front #(
    parameter int unsigned CW = 32,
    parameter int unsigned F  = 30,
    parameter int unsigned MW = 2 * (CW + 1) + 1,
    parameter int unsigned RW = 2 * MW + 2 + 2 * F + 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [5:0]           i_en,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_pts [9],
    output logic [5:0]           o_v,
    output unfn_pkg::t_ctl       o_ctl,
    output logic [RW-1:0]        o_s,
    output logic [2:0][RW-1:0]   o_r
);
    import unfn_pkg::*;

    localparam int unsigned EW  = CW + 1;
    localparam int unsigned PW  = 2 * EW;
    localparam int unsigned NW  = PW + 1;
    localparam int unsigned H   = (MW + 1) / 2;
    localparam int unsigned SQW = 2 * MW;
    localparam int unsigned SW  = SQW + 2;

    logic [5:0]           r_v;
    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    logic signed [PW-1:0] r_m1 [3];
    logic signed [PW-1:0] r_m2 [3];
    logic [MW-1:0]        r_mag [3];
    logic [2*H-1:0]       r_hh [3];
    logic [2*H-1:0]       r_hl [3];
    logic [2*H-1:0]       r_ll [3];
    logic [SQW-1:0]       r_sq [3];
    logic [2:0]           r_neg3, r_neg4, r_neg5, r_neg6;
    logic                 r_degen;
    logic [RW-1:0]        r_s;
    logic [2:0][RW-1:0]   r_r;

    logic signed [NW-1:0] n_n [3];
    logic [4*H-1:0]       n_sqw [3];
    logic [SW-1:0]        n_sum;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_n[i]   = NW'(r_m1[i]) - NW'(r_m2[i]);
            n_sqw[i] = ((4*H)'(r_hh[i]) << (2 * H)) + ((4*H)'(r_hl[i]) << (H + 1))
                       + (4*H)'(r_ll[i]);
        end
        n_sum = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (i_en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < 6; k++) begin
                if (i_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (i_en[0]) begin
                r_e1[i] <= EW'(i_pts[i]) - EW'(i_pts[3+i]);
                r_e2[i] <= EW'(i_pts[6+i]) - EW'(i_pts[3+i]);
            end
            if (i_en[1]) begin
                r_m1[i] <= PW'(r_e1[(i+1)%3]) * PW'(r_e2[(i+2)%3]);
                r_m2[i] <= PW'(r_e1[(i+2)%3]) * PW'(r_e2[(i+1)%3]);
            end
            if (i_en[2]) begin
                r_neg3[i] <= n_n[i][NW-1];
                r_mag[i]  <= n_n[i][NW-1] ? MW'(-n_n[i]) : MW'(n_n[i]);
            end
            // The square is split into half-width partial products.
            if (i_en[3]) begin
                r_hh[i] <= (2*H)'(r_mag[i][MW-1:H]) * (2*H)'(r_mag[i][MW-1:H]);
                r_hl[i] <= (2*H)'(r_mag[i][MW-1:H]) * (2*H)'(r_mag[i][H-1:0]);
                r_ll[i] <= (2*H)'(r_mag[i][H-1:0]) * (2*H)'(r_mag[i][H-1:0]);
            end
            if (i_en[4]) r_sq[i] <= SQW'(n_sqw[i]);
            if (i_en[5]) r_r[i] <= RW'(r_sq[i]) << (2 * F);
        end
        if (i_en[3]) r_neg4 <= r_neg3;
        if (i_en[4]) r_neg5 <= r_neg4;
        if (i_en[5]) begin
            r_neg6  <= r_neg5;
            r_s     <= RW'(n_sum);
            r_degen <= (n_sum == '0);
        end
    end

    assign o_v              = r_v;
    assign o_ctl.valid      = r_v[5];
    assign o_ctl.degenerate = r_degen;
    assign o_ctl.neg        = r_neg6;
    assign o_s              = r_s;
    assign o_r              = r_r;

endmodule

// File: design/unfn_cell.sv
// One quotient bit of the square-root division for all three components.
module unfn_cell #(
    parameter int unsigned RW = 199,
    parameter int unsigned QW = 31,
    parameter int unsigned B  = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  unfn_pkg::t_ctl       i_ctl,
    input  logic [RW-1:0]        i_s,
    input  logic [2:0][RW-1:0]   i_r,
    input  logic [2:0][RW-1:0]   i_y,
    input  logic [2:0][QW-1:0]   i_q,
    output unfn_pkg::t_ctl       o_ctl,
    output logic [RW-1:0]        o_s,
    output logic [2:0][RW-1:0]   o_r,
    output logic [2:0][RW-1:0]   o_y,
    output logic [2:0][QW-1:0]   o_q
);
    import unfn_pkg::*;

    t_ctl               r_ctl;
    logic [RW-1:0]      r_s;
    logic [2:0][RW-1:0] r_r, r_y;
    logic [2:0][QW-1:0] r_q;
    logic [2:0][RW-1:0] n_r, n_y;
    logic [2:0][QW-1:0] n_q;
    logic [RW-1:0]      w_t [3];

    // R holds N_i^2 * 2^(2F) - q^2 * S and Y holds q * S, so setting bit B
    // costs 2^(B+1) * Y + 2^(2B) * S.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_t[j] = (i_y[j] << (B + 1)) + (i_s << (2 * B));
            if (w_t[j] <= i_r[j]) begin
                n_r[j] = i_r[j] - w_t[j];
                n_y[j] = i_y[j] + (i_s << B);
                n_q[j] = i_q[j] | (QW'(1) << B);
            end else begin
                n_r[j] = i_r[j];
                n_y[j] = i_y[j];
                n_q[j] = i_q[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= i_s;
            r_r <= n_r;
            r_y <= n_y;
            r_q <= n_q;
        end
    end

    assign o_ctl = r_ctl;
    assign o_s   = r_s;
    assign o_r   = r_r;
    assign o_y   = r_y;
    assign o_q   = r_q;

endmodule
